[src/clb_pkg.sv]
//------------------------------------------------------------------------------
// clb_pkg
// Shared constants, opcodes and status codes of the cluster light binner.
//------------------------------------------------------------------------------
package clb_pkg;

  localparam int CLUSTERS_X = 16;
  localparam int CLUSTERS_Y = 8;
  localparam int CLUSTERS_Z = 8;
  localparam int MAX_LIGHTS = 64;
  localparam int POOL_DEPTH = 65536;

  localparam int NCLUSTERS = CLUSTERS_X * CLUSTERS_Y * CLUSTERS_Z;
  localparam int CW = $clog2(NCLUSTERS);
  localparam int LW = $clog2(MAX_LIGHTS);
  localparam int PW = $clog2(POOL_DEPTH);

  localparam logic [2:0] OP_START = 3'd0;
  localparam logic [2:0] OP_ADD   = 3'd1;
  localparam logic [2:0] OP_BUILD = 3'd2;
  localparam logic [2:0] OP_RDCL  = 3'd3;
  localparam logic [2:0] OP_RDPL  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_NOBLD = 2'd3;

  typedef struct packed {
    logic [3:0] x0;
    logic [3:0] x1;
    logic [2:0] y0;
    logic [2:0] y1;
    logic [2:0] z0;
    logic [2:0] z1;
  } box_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  light_index;
    logic [16:0] list_offset;
    logic [6:0]  list_length;
  } res_t;

  function automatic logic [CW-1:0] cell_of(input logic [3:0] x, input logic [2:0] y,
                                            input logic [2:0] z);
    return {z, y, x};
  endfunction

endpackage

[src/clb_mem.sv]
//------------------------------------------------------------------------------
// clb_mem
// Generic single-write, single-read synchronous RAM with registered read.
//------------------------------------------------------------------------------
module clb_mem #(
  parameter int DW = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[src/cluster_light_list_binning.sv]
//------------------------------------------------------------------------------
// cluster_light_list_binning
// Bins light boxes into a cluster grid by counting sort, builds pool lists.
//------------------------------------------------------------------------------
// channel | direction | ports
// in      | input     | in_valid, in_stall, in_opcode .. in_address
// out     | output    | out_valid, out_stall, out_status .. out_light_count
//
// An add walks every covered cluster with a read and a write of its count; a
// read item reads the count and offset memories or the pool. A build runs a
// prefix-sum pass over every cluster, reads each stored box and walks every covered
// cluster of every box, bounded by the cursor read-modify-write.
// After reset a clearing pass over every cluster runs with in_stall high.
// A start frame also clears the counts of every cluster.
// A result waits in an output register; the next item waits until it is taken.
//------------------------------------------------------------------------------
module cluster_light_list_binning
  import clb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_opcode,
  input  logic [3:0]  in_x_first,
  input  logic [3:0]  in_x_last,
  input  logic [2:0]  in_y_first,
  input  logic [2:0]  in_y_last,
  input  logic [2:0]  in_z_first,
  input  logic [2:0]  in_z_last,
  input  logic [15:0] in_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [5:0]  out_light_index,
  output logic [16:0] out_list_offset,
  output logic [6:0]  out_list_length,
  output logic [6:0]  out_peak_length,
  output logic [16:0] out_pool_used,
  output logic [6:0]  out_light_count
);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_WALK  = 4'd2;  // read count (add) or cursor (build) of cell
  localparam logic [3:0] S_WALKW = 4'd3;  // write count+1
  localparam logic [3:0] S_PRE   = 4'd4;  // read count for prefix
  localparam logic [3:0] S_PREW  = 4'd5;
  localparam logic [3:0] S_BOX   = 4'd6;  // read box
  localparam logic [3:0] S_BOXW  = 4'd7;
  localparam logic [3:0] S_SCAT  = 4'd8;  // read cursor
  localparam logic [3:0] S_SCATW = 4'd9;
  localparam logic [3:0] S_READ  = 4'd10;
  localparam logic [3:0] S_READW = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0]    state_r, state_nxt;
  logic [CW:0]   ccnt_r, ccnt_nxt;
  logic [6:0]    nlight_r, nlight_nxt;
  logic          built_r, built_nxt;
  logic [6:0]    peak_r, peak_nxt;
  logic [16:0]   used_r, used_nxt;
  logic [16:0]   run_r, run_nxt;
  logic          bld_r, bld_nxt;       // walk belongs to a build scatter
  logic [LW:0]   li_r, li_nxt;         // light being scattered
  box_t          box_r, box_nxt;
  logic [3:0]    x_r, x_nxt;
  logic [2:0]    y_r, y_nxt;
  logic [2:0]    z_r, z_nxt;
  logic [2:0]    op_r, op_nxt;
  logic [15:0]   addr_r, addr_nxt;
  res_t          res_r, res_nxt;
  logic          boot_r, boot_nxt;     // clearing pass after reset gives no result

  // memories
  logic          cnt_we;
  logic [CW-1:0] cnt_wa, cnt_ra;
  logic [6:0]    cnt_wd, cnt_rd;
  logic          off_we;
  logic [16:0]   off_rd;
  logic          cur_we;
  logic [CW-1:0] cur_wa, cur_ra;
  logic [16:0]   cur_wd, cur_rd;
  logic          box_we;
  logic [LW-1:0] box_wa, box_ra;
  box_t          box_wd, box_rd;
  logic          pool_we;
  logic [PW-1:0] pool_wa, pool_ra;
  logic [5:0]    pool_rd;

  clb_mem #(.DW(7), .DEPTH(NCLUSTERS)) u_cnt (.clk, .we(cnt_we), .waddr(cnt_wa),
    .wdata(cnt_wd), .raddr(cnt_ra), .rdata(cnt_rd));
  clb_mem #(.DW(17), .DEPTH(NCLUSTERS)) u_off (.clk, .we(off_we), .waddr(cur_wa),
    .wdata(cur_wd), .raddr(cnt_ra), .rdata(off_rd));
  clb_mem #(.DW(17), .DEPTH(NCLUSTERS)) u_cur (.clk, .we(cur_we), .waddr(cur_wa),
    .wdata(cur_wd), .raddr(cur_ra), .rdata(cur_rd));
  clb_mem #(.DW($bits(box_t)), .DEPTH(MAX_LIGHTS)) u_box (.clk, .we(box_we),
    .waddr(box_wa), .wdata(box_wd), .raddr(box_ra), .rdata(box_rd));
  clb_mem #(.DW(6), .DEPTH(POOL_DEPTH)) u_pool (.clk, .we(pool_we), .waddr(pool_wa),
    .wdata(li_r[5:0]), .raddr(pool_ra), .rdata(pool_rd));

  function automatic logic [3:0] clampx(input logic [3:0] v);
    return (32'(v) > CLUSTERS_X - 1) ? 4'(CLUSTERS_X - 1) : v;
  endfunction
  function automatic logic [2:0] clampy(input logic [2:0] v);
    return (32'(v) > CLUSTERS_Y - 1) ? 3'(CLUSTERS_Y - 1) : v;
  endfunction
  function automatic logic [2:0] clampz(input logic [2:0] v);
    return (32'(v) > CLUSTERS_Z - 1) ? 3'(CLUSTERS_Z - 1) : v;
  endfunction

  logic  accept;
  box_t  in_box;
  logic  empty_in, empty_r, last_cell;
  logic [CW-1:0] cur_cell;

  assign in_stall = (state_r != S_IDLE);
  assign accept = in_valid && !in_stall;
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    in_box.x0 = clampx(in_x_first);
    in_box.x1 = clampx(in_x_last);
    in_box.y0 = clampy(in_y_first);
    in_box.y1 = clampy(in_y_last);
    in_box.z0 = clampz(in_z_first);
    in_box.z1 = clampz(in_z_last);
  end
  assign empty_in = in_box.x0 > in_box.x1 || in_box.y0 > in_box.y1 ||
                    in_box.z0 > in_box.z1;
  assign empty_r = box_rd.x0 > box_rd.x1 || box_rd.y0 > box_rd.y1 ||
                   box_rd.z0 > box_rd.z1;
  assign cur_cell = cell_of(x_r, y_r, z_r);
  assign last_cell = (x_r == box_r.x1) && (y_r == box_r.y1) && (z_r == box_r.z1);

  always_comb begin
    state_nxt = state_r; ccnt_nxt = ccnt_r; nlight_nxt = nlight_r;
    built_nxt = built_r; peak_nxt = peak_r; used_nxt = used_r; run_nxt = run_r;
    bld_nxt = bld_r; li_nxt = li_r; box_nxt = box_r; x_nxt = x_r; y_nxt = y_r;
    z_nxt = z_r; op_nxt = op_r; addr_nxt = addr_r; res_nxt = res_r;
    boot_nxt = boot_r;
    cnt_we = 1'b0; cnt_wa = ccnt_r[CW-1:0]; cnt_wd = '0; cnt_ra = cur_cell;
    off_we = 1'b0; cur_we = 1'b0; cur_wa = ccnt_r[CW-1:0]; cur_wd = run_r;
    cur_ra = cur_cell; box_we = 1'b0; box_wa = nlight_r[LW-1:0]; box_wd = in_box;
    box_ra = li_r[LW-1:0]; pool_we = 1'b0; pool_wa = cur_rd[PW-1:0];
    pool_ra = addr_r[PW-1:0];
    case (state_r)
      S_CLR: begin
        cnt_we = 1'b1;
        ccnt_nxt = ccnt_r + 1'b1;
        if (ccnt_r == (CW+1)'(NCLUSTERS - 1)) begin
          state_nxt = boot_r ? S_IDLE : S_OUT;
          boot_nxt = 1'b0;
        end
      end
      S_IDLE: begin
        if (accept) begin
          op_nxt = in_opcode; addr_nxt = in_address; res_nxt = '0; ccnt_nxt = '0;
          case (in_opcode)
            OP_START: begin
              nlight_nxt = '0; built_nxt = 1'b0; state_nxt = S_CLR;
            end
            OP_ADD: begin
              if (32'(nlight_r) >= MAX_LIGHTS) begin
                res_nxt.status = ST_FULL; state_nxt = S_OUT;
              end else begin
                box_we = 1'b1;
                res_nxt.light_index = nlight_r[5:0];
                nlight_nxt = nlight_r + 1'b1;
                built_nxt = 1'b0;
                box_nxt = in_box; x_nxt = in_box.x0; y_nxt = in_box.y0;
                z_nxt = in_box.z0; bld_nxt = 1'b0;
                state_nxt = empty_in ? S_OUT : S_WALK;
              end
            end
            OP_BUILD: begin
              run_nxt = '0; peak_nxt = '0; state_nxt = S_PRE;
            end
            OP_RDCL, OP_RDPL: begin
              if (!built_r) begin
                res_nxt.status = ST_NOBLD; state_nxt = S_OUT;
              end else if ((in_opcode == OP_RDCL && 32'(in_address) >= NCLUSTERS) ||
                           (in_opcode == OP_RDPL && 17'(in_address) >= used_r)) begin
                res_nxt.status = ST_RANGE; state_nxt = S_OUT;
              end else begin
                state_nxt = S_READ;
              end
            end
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_WALK: state_nxt = bld_r ? S_SCATW : S_WALKW;
      S_SCAT: state_nxt = S_SCATW;
      S_WALKW, S_SCATW: begin
        if (bld_r) begin
          // Cursor bump for one covered cell, and pool write while the cursor is inside the pool.
          cur_we = 1'b1; cur_wa = cur_cell; cur_wd = cur_rd + 1'b1;
          if (cur_rd < 17'(POOL_DEPTH)) begin
            pool_we = 1'b1; used_nxt = used_r + 1'b1;
          end
        end else begin
          cnt_we = 1'b1; cnt_wa = cur_cell; cnt_wd = cnt_rd + 1'b1;
        end
        if (last_cell) begin
          if (bld_r) begin
            li_nxt = li_r + 1'b1; state_nxt = S_BOX;
          end else state_nxt = S_OUT;
        end else begin
          state_nxt = S_WALK;
          if (x_r != box_r.x1) x_nxt = x_r + 1'b1;
          else begin
            x_nxt = box_r.x0;
            if (y_r != box_r.y1) y_nxt = y_r + 1'b1;
            else begin
              y_nxt = box_r.y0; z_nxt = z_r + 1'b1;
            end
          end
        end
      end
      S_PRE: begin
        cnt_ra = ccnt_r[CW-1:0]; state_nxt = S_PREW;
      end
      S_PREW: begin
        off_we = 1'b1; cur_we = 1'b1;
        if (cnt_rd > peak_r) peak_nxt = cnt_rd;
        run_nxt = run_r + 17'(cnt_rd);
        ccnt_nxt = ccnt_r + 1'b1;
        if (ccnt_r == (CW+1)'(NCLUSTERS - 1)) begin
          li_nxt = '0; used_nxt = '0; bld_nxt = 1'b1; state_nxt = S_BOX;
        end else state_nxt = S_PRE;
      end
      S_BOX: begin
        if (li_r == nlight_r) begin
          built_nxt = 1'b1; state_nxt = S_OUT;
        end else state_nxt = S_BOXW;
      end
      S_BOXW: begin
        box_nxt = box_rd; x_nxt = box_rd.x0; y_nxt = box_rd.y0; z_nxt = box_rd.z0;
        if (empty_r) begin
          li_nxt = li_r + 1'b1; state_nxt = S_BOX;
        end else state_nxt = S_SCAT;
      end
      S_READ: begin
        cnt_ra = addr_r[CW-1:0]; state_nxt = S_READW;
      end
      S_READW: begin
        if (op_r == OP_RDCL) begin
          res_nxt.list_offset = off_rd; res_nxt.list_length = cnt_rd;
        end else res_nxt.light_index = pool_rd;
        state_nxt = S_OUT;
      end
      S_OUT: if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR; ccnt_r <= '0; nlight_r <= '0; built_r <= 1'b0;
      peak_r <= '0; used_r <= '0; res_r <= '0; bld_r <= 1'b0; boot_r <= 1'b1;
    end else begin
      state_r <= state_nxt; ccnt_r <= ccnt_nxt; nlight_r <= nlight_nxt;
      built_r <= built_nxt; peak_r <= peak_nxt; used_r <= used_nxt;
      res_r <= res_nxt; bld_r <= bld_nxt; boot_r <= boot_nxt;
    end
    run_r <= run_nxt; li_r <= li_nxt; box_r <= box_nxt; x_r <= x_nxt;
    y_r <= y_nxt; z_r <= z_nxt; op_r <= op_nxt; addr_r <= addr_nxt;
  end

  assign out_status = res_r.status;
  assign out_light_index = res_r.light_index;
  assign out_list_offset = res_r.list_offset;
  assign out_list_length = res_r.list_length;
  assign out_peak_length = peak_r;
  assign out_pool_used = used_r;
  assign out_light_count = nlight_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(nlight_r) <= MAX_LIGHTS) else $error("light count past table");
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(used_r) <= POOL_DEPTH) else $error("pool use past depth");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(res_r)) else $error("result lost");
endmodule
